// ----- rtl/binary_trie_max_xor_core_defines.svh -----
// Assertion macros shared by the trie max-XOR core.
`ifndef BINARY_TRIE_MAX_XOR_CORE_DEFINES_SVH
`define BINARY_TRIE_MAX_XOR_CORE_DEFINES_SVH

`ifndef SYNTHESIS
// Property must hold on every clock edge outside reset.
`define BTMX_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);
// Condition must never be seen outside reset.
`define BTMX_ASSERT_NEVER(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);
`else
`define BTMX_ASSERT(label, prop, msg)
`define BTMX_ASSERT_NEVER(label, cond, msg)
`endif

`endif

// ----- rtl/btmx_pkg.sv -----
// Shared types and constants of the trie max-XOR core.
`timescale 1ns / 1ps

package btmx_pkg;

	localparam int KEY_FIELD_W = 31;
	localparam int IN_TDATA_W  = 32;
	localparam int OUT_TDATA_W = 40;

	localparam logic MODE_INSERT = 1'b0;
	localparam logic MODE_QUERY  = 1'b1;

	typedef logic [KEY_FIELD_W-1:0] key_field_t;

	typedef struct packed {
		logic       mode;
		key_field_t key;
	} item_t;

	typedef struct packed {
		key_field_t max_xor;
		logic       found;
		logic       pool_full;
	} result_t;

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_WALK = 3'b010,
		ST_FIN  = 3'b100
	} state_t;

endpackage

// ----- rtl/btmx_child_mem.sv -----
// Child pointer store: zero-child and one-child node memories.
`timescale 1ns / 1ps

module btmx_child_mem #(
	parameter int NODE_COUNT = 4096,
	parameter int IDX_W      = 12
) (
	input  logic             clk,
	input  logic [IDX_W-1:0] rd_addr,
	input  logic [IDX_W-1:0] wr_addr,
	input  logic             wr_en,
	input  logic [IDX_W-1:0] wr_zero,
	input  logic [IDX_W-1:0] wr_one,
	output logic [IDX_W-1:0] rd_zero,
	output logic [IDX_W-1:0] rd_one
);

	logic [IDX_W-1:0] zero_mem [NODE_COUNT];
	logic [IDX_W-1:0] one_mem  [NODE_COUNT];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			zero_mem[wr_addr] <= wr_zero;
		end
		rd_zero <= zero_mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			one_mem[wr_addr] <= wr_one;
		end
		rd_one <= one_mem[rd_addr];
	end

endmodule

// ----- rtl/btmx_walker.sv -----
// Trie walk sequencer: node allocation, query descent and result build.
`timescale 1ns / 1ps
`include "binary_trie_max_xor_core_defines.svh"

module btmx_walker #(
	parameter int NODE_COUNT = 4096,
	parameter int KEY_BITS   = 31,
	parameter int IDX_W      = 12
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_ready,
	input  btmx_pkg::item_t   req,
	output logic              res_valid,
	input  logic              res_ready,
	output btmx_pkg::result_t res,
	output logic [IDX_W-1:0]  rd_addr,
	output logic [IDX_W-1:0]  wr_addr,
	output logic              wr_en,
	output logic [IDX_W-1:0]  wr_zero,
	output logic [IDX_W-1:0]  wr_one,
	input  logic [IDX_W-1:0]  rd_zero,
	input  logic [IDX_W-1:0]  rd_one
);

	localparam int NF_W  = IDX_W + 1;
	localparam int LVL_W = (KEY_BITS > 1) ? $clog2(KEY_BITS) : 1;
	localparam logic [NF_W-1:0] NF_LIMIT = NF_W'(NODE_COUNT - KEY_BITS);

	typedef logic [KEY_BITS-1:0] kb_t;
	typedef logic [LVL_W-1:0]    lvl_t;

	btmx_pkg::state_t state_q;
	lvl_t             lvl_q;
	kb_t              key_q;
	kb_t              res_q;
	logic [IDX_W-1:0] node_q;
	logic             mode_q;
	logic             alloc_q;
	logic [NF_W-1:0]  nf_q;
	logic             nonempty_q;
	logic             found_q;
	logic             full_q;

	logic             bit_c;
	logic             root_blank;
	logic [IDX_W-1:0] child0;
	logic [IDX_W-1:0] child1;
	logic [IDX_W-1:0] same_c;
	logic [IDX_W-1:0] opp_c;
	logic [IDX_W-1:0] keep_c;
	logic [IDX_W-1:0] nf_idx;
	logic [IDX_W-1:0] nxt;
	logic             take_opp;
	logic             need_alloc;
	logic             walking;
	logic             accept;
	logic             refuse;

	assign walking   = (state_q == btmx_pkg::ST_WALK);
	assign req_ready = (state_q == btmx_pkg::ST_IDLE);
	assign accept    = req_valid && req_ready;
	assign refuse    = (nf_q > NF_LIMIT);
	assign nf_idx    = nf_q[IDX_W-1:0];

	// Root entries hold stale contents until the first insert writes them.
	assign root_blank = !nonempty_q && (node_q == '0);
	assign bit_c      = key_q[lvl_q];
	assign child0     = root_blank ? '0 : rd_zero;
	assign child1     = root_blank ? '0 : rd_one;
	assign same_c     = bit_c ? child1 : child0;
	assign opp_c      = bit_c ? child0 : child1;
	assign take_opp   = (opp_c != '0);
	assign need_alloc = alloc_q || (same_c == '0);
	// Fresh nodes have no other child; an existing node keeps its own.
	assign keep_c     = alloc_q ? '0 : opp_c;

	always_comb begin
		if (mode_q == btmx_pkg::MODE_QUERY) begin
			nxt = take_opp ? opp_c : same_c;
		end else begin
			nxt = need_alloc ? nf_idx : same_c;
		end
	end

	assign rd_addr = walking ? nxt : '0;
	assign wr_addr = node_q;
	assign wr_en   = walking && (mode_q == btmx_pkg::MODE_INSERT) && need_alloc;
	assign wr_zero = bit_c ? keep_c : nf_idx;
	assign wr_one  = bit_c ? nf_idx : keep_c;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= btmx_pkg::ST_IDLE;
			nf_q       <= NF_W'(1);
			nonempty_q <= 1'b0;
		end else begin
			case (state_q)
				btmx_pkg::ST_IDLE: begin
					if (accept) begin
						if (req.mode == btmx_pkg::MODE_INSERT) begin
							state_q <= refuse ? btmx_pkg::ST_FIN : btmx_pkg::ST_WALK;
						end else begin
							state_q <= nonempty_q ? btmx_pkg::ST_WALK : btmx_pkg::ST_FIN;
						end
					end
				end
				btmx_pkg::ST_WALK: begin
					if (wr_en) begin
						nf_q <= nf_q + NF_W'(1);
					end
					if (lvl_q == '0) begin
						state_q <= btmx_pkg::ST_FIN;
						if (mode_q == btmx_pkg::MODE_INSERT) begin
							nonempty_q <= 1'b1;
						end
					end
				end
				btmx_pkg::ST_FIN: begin
					if (res_ready) begin
						state_q <= btmx_pkg::ST_IDLE;
					end
				end
				default: begin
					state_q <= btmx_pkg::ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			key_q   <= kb_t'(req.key);
			mode_q  <= req.mode;
			res_q   <= '0;
			node_q  <= '0;
			alloc_q <= 1'b0;
			lvl_q   <= lvl_t'(KEY_BITS - 1);
			found_q <= (req.mode == btmx_pkg::MODE_QUERY) && nonempty_q;
			full_q  <= (req.mode == btmx_pkg::MODE_INSERT) && refuse;
		end else if (walking) begin
			node_q <= nxt;
			lvl_q  <= lvl_q - lvl_t'(1);
			if (mode_q == btmx_pkg::MODE_QUERY) begin
				res_q[lvl_q] <= take_opp;
			end else begin
				alloc_q <= need_alloc;
			end
		end
	end

	assign res_valid     = (state_q == btmx_pkg::ST_FIN);
	assign res.max_xor   = btmx_pkg::key_field_t'(res_q);
	assign res.found     = found_q;
	assign res.pool_full = full_q;

	`BTMX_ASSERT(a_nf_bound, nf_q <= NF_W'(NODE_COUNT), "node pool overrun")
	`BTMX_ASSERT_NEVER(a_rw_same, wr_en && (rd_addr == wr_addr), "read and write hit one node")
	`BTMX_ASSERT(a_nf_step, wr_en |=> (nf_q == $past(nf_q) + NF_W'(1)), "allocation count slip")
	`BTMX_ASSERT(a_alloc_sticky, (walking && alloc_q) |=> (alloc_q || res_valid), "tail dropped")

endmodule

// ----- rtl/binary_trie_max_xor_core.sv -----
// Top level of the binary trie max-XOR core: stream ports and result register.
`timescale 1ns / 1ps

// Channel   Dir  tdata (low bit up)                     tuser
// s_axis    in   key[30:0], pad[31]                     mode (0 insert, 1 query)
// m_axis    out  max_xor[30:0], found, pool_full, pad   -
//
// Flow: a walking request passes through accept, one trie level per cycle and
//   finish; the chained child-memory read sets this pace.
// A refused insert or a query on an empty trie goes from accept straight to finish.
// Reset: nodes are cleared as they are allocated and the root reads empty until
//   the first insert, so there is no clearing pass after reset.
// Stalls: a finished result waits in the output register while the next request
//   is taken; the walker holds in its finish state only if that register is full.

module binary_trie_max_xor_core #(
	parameter int NODE_COUNT = 4096,
	parameter int KEY_BITS   = 31
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_axis_tvalid,
	output logic                              s_axis_tready,
	input  logic [btmx_pkg::IN_TDATA_W-1:0]   s_axis_tdata,   // key[30:0], pad
	input  logic                              s_axis_tuser,   // mode
	output logic                              m_axis_tvalid,
	input  logic                              m_axis_tready,
	output logic [btmx_pkg::OUT_TDATA_W-1:0]  m_axis_tdata    // max_xor, found, pool_full
);

	localparam int IDX_W = $clog2(NODE_COUNT);
	localparam int PAD_W = btmx_pkg::OUT_TDATA_W - btmx_pkg::KEY_FIELD_W - 2;

	btmx_pkg::item_t   req;
	btmx_pkg::result_t res;
	btmx_pkg::result_t out_q;
	logic              out_valid_q;
	logic              res_valid;
	logic              res_ready;

	logic [IDX_W-1:0] rd_addr;
	logic [IDX_W-1:0] wr_addr;
	logic             wr_en;
	logic [IDX_W-1:0] wr_zero;
	logic [IDX_W-1:0] wr_one;
	logic [IDX_W-1:0] rd_zero;
	logic [IDX_W-1:0] rd_one;

	assign req.mode = s_axis_tuser;
	assign req.key  = s_axis_tdata[btmx_pkg::KEY_FIELD_W-1:0];

	btmx_walker #(
		.NODE_COUNT (NODE_COUNT),
		.KEY_BITS   (KEY_BITS),
		.IDX_W      (IDX_W)
	) u_walker (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (s_axis_tvalid),
		.req_ready (s_axis_tready),
		.req       (req),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res),
		.rd_addr   (rd_addr),
		.wr_addr   (wr_addr),
		.wr_en     (wr_en),
		.wr_zero   (wr_zero),
		.wr_one    (wr_one),
		.rd_zero   (rd_zero),
		.rd_one    (rd_one)
	);

	btmx_child_mem #(
		.NODE_COUNT (NODE_COUNT),
		.IDX_W      (IDX_W)
	) u_child_mem (
		.clk     (clk),
		.rd_addr (rd_addr),
		.wr_addr (wr_addr),
		.wr_en   (wr_en),
		.wr_zero (wr_zero),
		.wr_one  (wr_one),
		.rd_zero (rd_zero),
		.rd_one  (rd_one)
	);

	// Output register: refills in the cycle the downstream side drains it.
	assign res_ready = !out_valid_q || m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_ready) begin
			out_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_ready && res_valid) begin
			out_q <= res;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {{PAD_W{1'b0}}, out_q.pool_full, out_q.found, out_q.max_xor};

endmodule
